// ===== src/block_padded_base32_label_encoder_assert.svh =====
`ifndef BLOCK_PADDED_BASE32_LABEL_ENCODER_ASSERT_SVH
`define BLOCK_PADDED_BASE32_LABEL_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPB32_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpb32 same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BPB32_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpb32 next-cycle check failed");

`endif

// ===== src/bpb32_pkg.sv =====
package bpb32_pkg;

  localparam int BLOCK_BYTES_DEF = 16;
  localparam int MAX_RESULTS     = 27;
  localparam int CODE_W          = 5;
  localparam int SYM_W           = 8;
  localparam int ACC_W           = 12;
  localparam int HELD_W          = 4;
  localparam int RES_CNT_W       = 5;
  localparam int CFG_REGS        = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [SYM_W-1:0]  DOT_SYMBOL = 8'h2E;
  localparam logic [CODE_W-1:0] CODE_MASK  = 5'h1F;

  typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] alphabet_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_PAD,
    ST_REM,
    ST_DOT
  } state_t;

  typedef struct packed {
    logic load;
    logic pad;
    logic shift_emit;
    logic rem_emit;
    logic dot_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ge10;
    logic five_held;
    logic block_full;
    logic last;
    logic push_ok;
  } dp_status_t;

  function automatic logic [SYM_W-1:0] lookup(alphabet_t alph, logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    c = code & CODE_MASK;
    return alph[c[4:3]][{c[2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

// ===== src/bpb32_if.sv =====
interface bpb32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bpb32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink (input valid, input symbol, input is_last, output ready);
endinterface

// ===== src/block_padded_base32_label_encoder.sv =====
// A byte is loaded into the accumulator on its transfer, and its first symbol is then registered
// into the output register once that register is free. Each byte yields one or two symbols, and
// no new byte is accepted until they are emitted. Closing a block adds the leftover symbol, if any, then the dot.
// A last byte also runs a pad step plus its symbols for each zero byte filling the block.
// Reset is synchronous and clears the bit state, the output valid flag and the alphabet to zero.
module block_padded_base32_label_encoder #(
  parameter int BLOCK_BYTES = bpb32_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bpb32_in_if.sink                         in_ch,
  bpb32_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [bpb32_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpb32_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpb32_pkg::*;

  `include "block_padded_base32_label_encoder_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  bpb32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpb32_dp #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

  `BPB32_ASSERT_NXT(a_busy_after_transfer, in_ch.valid && in_ready, !in_ready)
  `BPB32_ASSERT_IMP(a_no_emit_while_idle, in_ready, !(cmd.shift_emit || cmd.rem_emit || cmd.dot_emit))
  `BPB32_ASSERT_IMP(a_last_is_dot, out_ch.valid && out_ch.is_last, out_ch.symbol == DOT_SYMBOL)

endmodule

// ===== src/bpb32_ctrl.sv =====
module bpb32_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bpb32_pkg::dp_status_t status,
  output bpb32_pkg::dp_cmd_t    cmd
);
  import bpb32_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.push_ok) begin
          if (status.ge10) begin
            state_next = ST_EMIT;
          end else if (status.last && !status.block_full) begin
            state_next = ST_PAD;
          end else if (status.last || status.block_full) begin
            state_next = status.five_held ? ST_DOT : ST_REM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        state_next = ST_EMIT;
      end
      ST_REM: begin
        if (status.push_ok) begin
          state_next = ST_DOT;
        end
      end
      ST_DOT: begin
        if (status.push_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && in_valid;
    cmd.pad        = (state == ST_PAD);
    cmd.shift_emit = (state == ST_EMIT) && status.push_ok;
    cmd.rem_emit   = (state == ST_REM) && status.push_ok;
    cmd.dot_emit   = (state == ST_DOT) && status.push_ok;
  end

endmodule

// ===== src/bpb32_dp.sv =====
module bpb32_dp #(
  parameter int BLOCK_BYTES = bpb32_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  logic                             cfg_we,
  input  logic [bpb32_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpb32_pkg::CFG_DATA_W-1:0] cfg_data,
  input  bpb32_pkg::dp_cmd_t               cmd,
  output bpb32_pkg::dp_status_t            status,
  bpb32_out_if.source                      out_ch
);
  import bpb32_pkg::*;

  localparam int BYTES_W = $clog2(BLOCK_BYTES + 1);

  alphabet_t            alphabet;
  logic [ACC_W-1:0]     acc;
  logic [HELD_W-1:0]    held;
  logic [BYTES_W-1:0]   bytes_cnt;
  logic                 last_flag;
  logic [RES_CNT_W-1:0] res_cnt;
  logic                 out_valid;
  logic [SYM_W-1:0]     out_symbol;
  logic                 out_is_last;

  logic             trunc;
  logic             emit;
  logic             push;
  logic [SYM_W-1:0] emit_symbol;

  assign trunc       = (res_cnt >= RES_CNT_W'(MAX_RESULTS));
  assign emit        = cmd.shift_emit || cmd.rem_emit || cmd.dot_emit;
  assign push        = emit && !trunc;
  assign emit_symbol = cmd.dot_emit ? DOT_SYMBOL : lookup(alphabet, acc[CODE_W-1:0]);

  assign status.ge10       = (held >= HELD_W'(10));
  assign status.five_held  = (held == HELD_W'(5));
  assign status.block_full = (bytes_cnt >= BYTES_W'(BLOCK_BYTES));
  assign status.last       = last_flag;
  assign status.push_ok    = !out_valid || out_ch.ready || trunc;

  assign out_ch.valid   = out_valid;
  assign out_ch.symbol  = out_symbol;
  assign out_ch.is_last = out_is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= '0;
    end else if (cfg_we) begin
      alphabet[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held      <= '0;
      bytes_cnt <= '0;
      last_flag <= 1'b0;
      res_cnt   <= '0;
    end else begin
      if (cmd.load) begin
        acc       <= acc | ACC_W'({4'b0000, data_byte} << held);
        held      <= held + HELD_W'(8);
        bytes_cnt <= bytes_cnt + BYTES_W'(1);
        last_flag <= last_byte;
        res_cnt   <= '0;
      end else begin
        if (cmd.pad) begin
          held      <= held + HELD_W'(8);
          bytes_cnt <= bytes_cnt + BYTES_W'(1);
        end
        if (cmd.shift_emit) begin
          acc  <= acc >> CODE_W;
          held <= held - HELD_W'(CODE_W);
        end
        if (cmd.rem_emit) begin
          acc  <= '0;
          held <= '0;
        end
        if (cmd.dot_emit) begin
          acc       <= '0;
          held      <= '0;
          bytes_cnt <= '0;
          last_flag <= 1'b0;
        end
        if (push) begin
          res_cnt <= res_cnt + RES_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_symbol  <= emit_symbol;
      out_is_last <= cmd.dot_emit && last_flag;
    end
  end

endmodule

// ===== verif/block_padded_base32_label_encoder_tb.sv =====
`timescale 1ns / 100ps

module block_padded_base32_label_encoder_tb;
  import bpb32_pkg::*;

  localparam int BLOCK_LEN    = BLOCK_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    ALPHABET_WORD0,
    ALPHABET_WORD1,
    ALPHABET_WORD2,
    ALPHABET_WORD3
  } alphabet_reg_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
  } label_symbol_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpb32_in_if  in_ch ();
  bpb32_out_if out_ch ();

  block_padded_base32_label_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  alphabet_t         alphabet_model = '0;
  logic [ACC_W-1:0]  acc_bits = '0;
  logic [HELD_W-1:0] acc_count = '0;
  logic [4:0]        block_fill = '0;
  label_symbol_t     pending_symbols[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures       = 0;
  int bytes_sent     = 0;
  int symbols_seen   = 0;
  int messages_done  = 0;
  int quiet_cycles   = 0;

  function automatic logic [SYM_W-1:0] map_code(input logic [CODE_W-1:0] code);
    return SYM_W'(alphabet_model[code[4:3]] >> (8 * code[2:0]));
  endfunction

  task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic last, inout int produced);
    if (produced < MAX_RESULTS) begin
      pending_symbols.push_back('{symbol: sym, is_last: last});
      produced++;
    end
  endtask

  task automatic pack_byte(input logic [7:0] data, inout int produced);
    acc_bits = acc_bits | (ACC_W'(data) << acc_count);
    acc_count = acc_count + 4'd8;
    while (acc_count >= 5) begin
      push_symbol(map_code(acc_bits[4:0]), 1'b0, produced);
      acc_bits = acc_bits >> 5;
      acc_count = acc_count - 4'd5;
    end
    block_fill = block_fill + 5'd1;
  endtask

  task automatic encode_byte(input logic [7:0] data, input logic last);
    int produced;
    produced = 0;
    pack_byte(data, produced);
    if (last) begin
      while (block_fill < BLOCK_LEN)
        pack_byte(8'h00, produced);
    end
    if (last || block_fill >= BLOCK_LEN) begin
      if (acc_count > 0)
        push_symbol(map_code(acc_bits[4:0]), 1'b0, produced);
      push_symbol(DOT_SYMBOL, last, produced);
      acc_bits = '0;
      acc_count = '0;
      block_fill = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    encode_byte(data, last);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_symbols.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_alphabet_word(input alphabet_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    alphabet_model[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_alphabet(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                               input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3);
    wait_drained();
    write_alphabet_word(ALPHABET_WORD0, w0);
    write_alphabet_word(ALPHABET_WORD1, w1);
    write_alphabet_word(ALPHABET_WORD2, w2);
    write_alphabet_word(ALPHABET_WORD3, w3);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_alphabet();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_directed_blocks();
    logic [7:0] pattern [BLOCK_LEN] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                                        8'h7F, 8'hFE, 8'h00, 8'hFF, 8'h12, 8'h34, 8'hC3, 8'h3C};
    load_alphabet("hgfedcba", "ponmlkji", "xwvutsrq", "765432zy");
    for (int i = 0; i < BLOCK_LEN; i++)
      send_byte(pattern[i], i == BLOCK_LEN - 1);
    send_byte(8'hFF, 1'b1);
    for (int i = 1; i <= 4; i++)
      send_byte(8'(i), i == 4);
  endtask

  task automatic run_random_phase(input int item_count, input int idle_pct, input int stall_pct);
    int sent;
    int msg_len;
    int pick;
    logic [7:0] data;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_count) begin
      pick = $urandom_range(9);
      if (pick < 2)
        msg_len = BLOCK_LEN;
      else if (pick == 2)
        msg_len = 2 * BLOCK_LEN;
      else
        msg_len = $urandom_range(1, 40);
      for (int i = 0; i < msg_len && sent < item_count; i++) begin
        pick = $urandom_range(15);
        data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
        send_byte(data, i == msg_len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_no_idle();
    load_alphabet(random_word(), random_word(), random_word(), random_word());
    run_random_phase(70, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    load_alphabet('1, '1, '1, '1);
    run_random_phase(70, 49, 0);
  endtask

  task automatic test_random_receiver_stall();
    load_alphabet('0, '0, '0, '0);
    run_random_phase(70, 0, 49);
  endtask

  task automatic test_random_both_idle();
    load_alphabet("hgfedcba", "ponmlkji", "xwvutsrq", random_word());
    run_random_phase(70, 38, 38);
  endtask

  always @(posedge clk) begin
    label_symbol_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      symbols_seen++;
      if (out_ch.is_last === 1'b1)
        messages_done++;
      if (pending_symbols.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected transfer: symbol %h is_last %b", out_ch.symbol, out_ch.is_last);
      end else begin
        want = pending_symbols.pop_front();
        if (out_ch.symbol !== want.symbol || out_ch.is_last !== want.is_last) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("mismatch: symbol expected %h actual %h, is_last expected %b actual %b",
                     want.symbol, out_ch.symbol, want.is_last, out_ch.is_last);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= ALPHABET_WORD0;
    cfg_data        <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_alphabet();
    test_directed_blocks();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_drained();

    $display("Sent %0d bytes; checked %0d symbols closing %0d messages.",
             bytes_sent, symbols_seen, messages_done);
    $display("Alphabets: reset, standard, random, all ones, all zeros; four idling phases.");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bpb32_pkg.sv
src/bpb32_if.sv
src/bpb32_ctrl.sv
src/bpb32_dp.sv
src/block_padded_base32_label_encoder.sv
verif/block_padded_base32_label_encoder_tb.sv
